// File: hw/rtl/assert_macros.svh
// assertion helpers shared by the codec modules
// each macro expects i_clk and i_rst_n in the enclosing module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define DPC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// consequence holds in the cycle after the antecedent
`define DPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/dpc_pkg.sv
package dpc_pkg;

    // register indexes on the configuration port
    localparam logic REG_DIRECTION    = 1'b0;
    localparam logic REG_TABLE_SELECT = 1'b1;

    // direction codes
    localparam logic DIR_COMPRESS   = 1'b0;
    localparam logic DIR_DECOMPRESS = 1'b1;

    // table codes
    localparam logic TBL_NUMERIC = 1'b0;
    localparam logic TBL_LETTER  = 1'b1;

    localparam logic [7:0] CODE_BASE = 8'd128;
    localparam int NUM_LEN1 = 11;
    localparam int NUM_LEN2 = 11;
    localparam int LET_LEN1 = 16;
    localparam int LET_LEN2 = 8;

    // reciprocal of 11 as 187 / 2048, exact for indexes below 121
    localparam logic [7:0] RECIP_11 = 8'd187;
    localparam int RECIP_SHIFT = 11;

    localparam logic [7:0] NUM_A1 [NUM_LEN1] = '{
        8'h7C, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};
    localparam logic [7:0] NUM_A2 [NUM_LEN2] = '{
        8'h2C, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};
    localparam logic [7:0] LET_A1 [LET_LEN1] = '{
        8'h20, 8'h74, 8'h65, 8'h69, 8'h73, 8'h61, 8'h70, 8'h72,
        8'h6E, 8'h6C, 8'h28, 8'h6F, 8'h66, 8'h29, 8'h3D, 8'h63};
    localparam logic [7:0] LET_A2 [LET_LEN2] = '{
        8'h20, 8'h74, 8'h6E, 8'h65, 8'h72, 8'h70, 8'h6C, 8'h61};

    // position of a byte in an alphabet
    typedef struct packed {
        logic       hit;
        logic [3:0] pos;
    } t_lookup;

    // one queued job: one or two output bytes
    typedef struct packed {
        logic       two;
        logic [7:0] b0;
        logic [7:0] b1;
    } t_job;

    function automatic t_lookup find_a1(logic sel, logic [7:0] b);
        t_lookup res;
        res = '0;
        if (sel == TBL_LETTER) begin
            for (int k = 0; k < LET_LEN1; k++) begin
                if (LET_A1[k] == b) begin
                    res.hit = 1'b1;
                    res.pos = 4'(k);
                end
            end
        end else begin
            for (int k = 0; k < NUM_LEN1; k++) begin
                if (NUM_A1[k] == b) begin
                    res.hit = 1'b1;
                    res.pos = 4'(k);
                end
            end
        end
        return res;
    endfunction

    function automatic t_lookup find_a2(logic sel, logic [7:0] b);
        t_lookup res;
        res = '0;
        if (sel == TBL_LETTER) begin
            for (int k = 0; k < LET_LEN2; k++) begin
                if (LET_A2[k] == b) begin
                    res.hit = 1'b1;
                    res.pos = 4'(k);
                end
            end
        end else begin
            for (int k = 0; k < NUM_LEN2; k++) begin
                if (NUM_A2[k] == b) begin
                    res.hit = 1'b1;
                    res.pos = 4'(k);
                end
            end
        end
        return res;
    endfunction

    function automatic logic [7:0] char_a1(logic sel, logic [3:0] pos);
        logic [7:0] res;
        res = '0;
        if (sel == TBL_LETTER) begin
            res = LET_A1[pos];
        end else if (pos < 4'(NUM_LEN1)) begin
            res = NUM_A1[pos];
        end
        return res;
    endfunction

    function automatic logic [7:0] char_a2(logic sel, logic [3:0] pos);
        logic [7:0] res;
        res = '0;
        if (sel == TBL_LETTER) begin
            if (pos < 4'(LET_LEN2)) begin
                res = LET_A2[pos[2:0]];
            end
        end else if (pos < 4'(NUM_LEN2)) begin
            res = NUM_A2[pos];
        end
        return res;
    endfunction

endpackage

// File: hw/rtl/dpc_front.sv
module dpc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_addr,
    input  logic          i_cfg_wdata,
    input  logic          i_accept,
    input  logic [7:0]    i_data_byte,
    input  logic          i_end_of_stream,
    output logic          o_push,
    output dpc_pkg::t_job o_job
);
    import dpc_pkg::*;

    logic       r_direction;
    logic       r_table_select;
    logic       r_held_valid;
    logic [7:0] r_held_char;
    logic       n_held_valid;
    logic [7:0] n_held_char;

    t_lookup    held_a1;
    t_lookup    new_a1;
    t_lookup    new_a2;
    logic [7:0] pair_code;
    logic [6:0] idx;
    logic [14:0] idx_prod;
    logic [3:0] dec_i;
    logic [3:0] dec_j;
    logic       in_table;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction    <= DIR_COMPRESS;
            r_table_select <= TBL_NUMERIC;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_DIRECTION:    r_direction    <= i_cfg_wdata;
                REG_TABLE_SELECT: r_table_select <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // alphabet lookups
    always_comb begin
        held_a1 = find_a1(r_table_select, r_held_char);
        new_a1  = find_a1(r_table_select, i_data_byte);
        new_a2  = find_a2(r_table_select, i_data_byte);
    end

    // pair code: base plus row times second alphabet length plus column
    always_comb begin
        if (r_table_select == TBL_LETTER) begin
            pair_code = CODE_BASE + {1'b0, held_a1.pos[3:0], new_a2.pos[2:0]};
        end else begin
            pair_code = CODE_BASE + {1'b0, held_a1.pos, 3'b000}
                        + {3'b000, held_a1.pos, 1'b0} + {4'b0000, held_a1.pos}
                        + {4'b0000, new_a2.pos};
        end
    end

    // code index split into row and column
    always_comb begin
        idx      = i_data_byte[6:0];
        idx_prod = 15'(idx) * 15'(RECIP_11);
        if (r_table_select == TBL_LETTER) begin
            in_table = i_data_byte[7];
            dec_i    = idx[6:3];
            dec_j    = {1'b0, idx[2:0]};
        end else begin
            in_table = i_data_byte[7] && (idx < 7'(NUM_LEN1 * NUM_LEN2));
            dec_i    = idx_prod[RECIP_SHIFT +: 4];
            dec_j    = 4'(idx - 7'(dec_i) * 7'(NUM_LEN2));
        end
    end

    // classify the accepted byte into a job
    always_comb begin
        o_push       = 1'b0;
        o_job        = '0;
        n_held_valid = r_held_valid;
        n_held_char  = r_held_char;
        if (i_accept) begin
            if (r_direction == DIR_DECOMPRESS) begin
                o_push = 1'b1;
                if (in_table) begin
                    o_job.two = 1'b1;
                    o_job.b0  = char_a1(r_table_select, dec_i);
                    o_job.b1  = char_a2(r_table_select, dec_j);
                end else begin
                    o_job.b0 = i_data_byte;
                end
            end else begin
                n_held_valid = 1'b0;
                n_held_char  = '0;
                if (r_held_valid && held_a1.hit && new_a2.hit) begin
                    o_push   = 1'b1;
                    o_job.b0 = pair_code;
                end else if (r_held_valid) begin
                    o_push   = 1'b1;
                    o_job.b0 = r_held_char;
                    if (!i_end_of_stream && new_a1.hit) begin
                        n_held_valid = 1'b1;
                        n_held_char  = i_data_byte;
                    end else begin
                        o_job.two = 1'b1;
                        o_job.b1  = i_data_byte;
                    end
                end else if (!i_end_of_stream && new_a1.hit) begin
                    n_held_valid = 1'b1;
                    n_held_char  = i_data_byte;
                end else begin
                    o_push   = 1'b1;
                    o_job.b0 = i_data_byte;
                end
            end
        end
    end

    // held byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_held_char  <= '0;
        end else begin
            r_held_valid <= n_held_valid;
            r_held_char  <= n_held_char;
        end
    end

`include "assert_macros.svh"

    `DPC_ASSERT_NEXT(a_eos_flushes, i_accept && r_direction == DIR_COMPRESS && i_end_of_stream, !r_held_valid, "byte still held after end of stream")
    `DPC_ASSERT(a_hold_silent, !(o_push == 1'b0 && i_accept && r_direction == DIR_COMPRESS && r_held_valid), "held byte dropped without a transfer")
    `DPC_ASSERT_NEXT(a_decomp_keeps, i_accept && r_direction == DIR_DECOMPRESS, $stable(r_held_valid), "held state changed in decompress mode")

endmodule

// File: hw/rtl/dpc_queue.sv
module dpc_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dpc_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_valid,
    output dpc_pkg::t_job o_job,
    output logic          o_full
);
    import dpc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_job   = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`include "assert_macros.svh"

    `DPC_ASSERT(a_no_overflow, !(i_push && o_full), "push into full queue")
    `DPC_ASSERT(a_no_underflow, !(i_pop && !o_valid), "pop from empty queue")
    `DPC_ASSERT(a_count_range, r_count <= CNT_W'(DEPTH), "queue count out of range")

endmodule

// File: hw/rtl/dpc_back.sv
module dpc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  dpc_pkg::t_job i_q_job,
    output logic          o_q_pop,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [7:0]    o_m_tdata,
    output logic          o_m_tlast
);
    import dpc_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_pend;
    logic [7:0] r_second;
    logic       take;
    logic       slot_free;

    assign take      = r_valid && i_m_tready;
    assign slot_free = !r_valid || take;
    assign o_q_pop   = slot_free && !r_pend && i_q_valid;

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_byte;
    assign o_m_tlast  = r_last;

    // output register, second byte of a job follows the first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_last  <= 1'b0;
            r_pend  <= 1'b0;
        end else if (slot_free) begin
            if (r_pend) begin
                r_valid <= 1'b1;
                r_last  <= 1'b1;
                r_pend  <= 1'b0;
            end else if (i_q_valid) begin
                r_valid <= 1'b1;
                r_last  <= !i_q_job.two;
                r_pend  <= i_q_job.two;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (slot_free) begin
            if (r_pend) begin
                r_byte <= r_second;
            end else if (i_q_valid) begin
                r_byte   <= i_q_job.b0;
                r_second <= i_q_job.b1;
            end
        end
    end

`include "assert_macros.svh"

    `DPC_ASSERT(a_pend_shows_first, !r_pend || (r_valid && !r_last), "second byte pending without first shown")
    `DPC_ASSERT_NEXT(a_second_follows, r_pend && take, r_valid && r_last, "second byte of job not sent next")

endmodule

// File: hw/rtl/digraph_pair_codec.sv
// digram pair codec, one input byte accepted per cycle while the job queue is not full
// path: the front classifies the accepted byte, the job queue registers the job, then the output register
// jobs are pushed at one item per cycle while the queue is not full; a job with two result bytes holds the
// output register for both bytes, the job queue between front and back absorbs the difference
// reset: synchronous active-low i_rst_n clears control registers, held byte and queue; compress, numeric

module digraph_pair_codec #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_addr,
    input  logic       i_cfg_wdata,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] data_byte
    input  logic       i_s_tlast,   // end_of_stream
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tlast    // last
);
    import dpc_pkg::*;

    logic accept;
    logic push;
    t_job push_job;
    logic q_valid;
    logic q_full;
    logic q_pop;
    t_job q_job;

    assign o_s_tready = !q_full;
    assign accept     = i_s_tvalid && o_s_tready;

    // classify and build jobs
    dpc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_accept        (accept),
        .i_data_byte     (i_s_tdata),
        .i_end_of_stream (i_s_tlast),
        .o_push          (push),
        .o_job           (push_job)
    );

    // job queue
    dpc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_job),
        .o_full  (q_full)
    );

    // serialize jobs onto the output stream
    dpc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_job    (q_job),
        .o_q_pop    (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
